### sv/fblm_pkg.sv
// Shared constants, types and helpers of the fixed block free list manager.
`timescale 1ns / 1ps

package fblm_pkg;

    // Pool geometry. Block indexes are 8 bits wide, so the pool holds at most 256 blocks.
    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [1:0] STAT_NONE_USED = 2'd2;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and read the head block's link
        logic execute;  // apply the request and load the result registers
    } t_dp_cmd;

    // Clamp a written pool size into 1..MAX_BLOCKS.
    function automatic logic [CNT_W-1:0] clamp_pool(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] result;
        result = value;
        if (value == '0) begin
            result = CNT_W'(1);
        end else if (value > CNT_W'(MAX_BLOCKS)) begin
            result = CNT_W'(MAX_BLOCKS);
        end
        return result;
    endfunction

endpackage

### sv/fblm_ctrl.sv
// Controller state machine of the fixed block free list manager.
`timescale 1ns / 1ps

module fblm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output fblm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

### sv/fblm_datapath.sv
// Datapath of the fixed block free list manager: list registers, link memory and results.
`timescale 1ns / 1ps

module fblm_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fblm_pkg::t_dp_cmd           i_cmd,
    input  logic [1:0]                  i_kind,
    input  logic [fblm_pkg::IDX_W-1:0]  i_block,
    input  logic                        i_cfg_we,
    input  logic [fblm_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic [fblm_pkg::IDX_W-1:0]  o_granted_block,
    output logic [1:0]                  o_status,
    output logic [fblm_pkg::CNT_W-1:0]  o_free_count
);

    localparam int IW = fblm_pkg::IDX_W;
    localparam int CW = fblm_pkg::CNT_W;

    // Link memory: undefined until written, written only by frees.
    logic [IW-1:0] r_link_mem [fblm_pkg::MAX_BLOCKS];
    logic [IW-1:0] r_link_rd;

    // Latched request.
    logic [1:0]    r_kind;
    logic [IW-1:0] r_blk;

    // List state.
    logic [CW-1:0] r_pool,  n_pool;
    logic [IW-1:0] r_head,  n_head;
    logic [IW-1:0] r_tail,  n_tail;
    logic          r_empty, n_empty;
    logic [CW-1:0] r_used,  n_used;
    logic [CW-1:0] r_fresh, n_fresh;

    // Results.
    logic [IW-1:0] r_granted, n_granted;
    logic [1:0]    r_status,  n_status;
    logic [CW-1:0] r_free,    n_free;

    logic          link_we;
    logic [CW-1:0] head_ext;
    logic [CW-1:0] head_succ;
    logic [CW:0]   used_plus;
    logic [CW-1:0] cfg_pool;

    assign head_ext  = {1'b0, r_head};
    assign head_succ = head_ext + CW'(1);
    assign used_plus = {1'b0, r_used} + (CW+1)'(1);
    assign cfg_pool  = fblm_pkg::clamp_pool(i_cfg_wdata);

    always_comb begin
        n_pool    = r_pool;
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_used    = r_used;
        n_fresh   = r_fresh;
        n_granted = '0;
        n_status  = fblm_pkg::STAT_OK;
        link_we   = 1'b0;

        case (r_kind)
            fblm_pkg::KIND_ALLOC: begin
                if (r_empty || (r_used >= r_pool)) begin
                    n_status = fblm_pkg::STAT_EXHAUSTED;
                end else begin
                    n_granted = r_head;
                    if ((r_head == r_tail) || (used_plus >= {1'b0, r_pool})) begin
                        n_empty = 1'b1;
                    end else if ((head_ext >= r_fresh) && (head_succ < r_pool)) begin
                        // Blocks not handed out since init chain to their successor.
                        n_head = head_succ[IW-1:0];
                    end else begin
                        n_head = r_link_rd;
                    end
                    if (head_ext >= r_fresh) begin
                        n_fresh = head_succ;
                    end
                    n_used = used_plus[CW-1:0];
                end
            end
            fblm_pkg::KIND_FREE: begin
                if (r_used == '0) begin
                    n_status = fblm_pkg::STAT_NONE_USED;
                end else if ({1'b0, r_blk} >= r_pool) begin
                    n_status = fblm_pkg::STAT_BAD_INDEX;
                end else begin
                    if (r_empty) begin
                        n_head  = r_blk;
                        n_empty = 1'b0;
                    end else begin
                        link_we = 1'b1;
                    end
                    n_tail = r_blk;
                    n_used = r_used - CW'(1);
                end
            end
            fblm_pkg::KIND_RELEASE: begin
                n_head  = '0;
                n_tail  = IW'(r_pool - CW'(1));
                n_empty = 1'b0;
                n_used  = '0;
                n_fresh = '0;
            end
            default: begin
            end
        endcase

        n_free = r_pool - n_used;
    end

    // Link memory with registered read of the head block, issued when a request is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && link_we) begin
            r_link_mem[r_tail] <= r_blk;
        end
        if (i_cmd.capture) begin
            r_link_rd <= r_link_mem[r_head];
        end
    end

    // Request and result registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_blk  <= i_block;
        end
        if (i_cmd.execute) begin
            r_granted <= n_granted;
            r_status  <= n_status;
            r_free    <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool  <= CW'(fblm_pkg::MAX_BLOCKS);
            r_head  <= '0;
            r_tail  <= IW'(fblm_pkg::MAX_BLOCKS - 1);
            r_empty <= 1'b0;
            r_used  <= '0;
            r_fresh <= '0;
        end else if (i_cfg_we) begin
            r_pool  <= cfg_pool;
            r_head  <= '0;
            r_tail  <= IW'(cfg_pool - CW'(1));
            r_empty <= 1'b0;
            r_used  <= '0;
            r_fresh <= '0;
        end else if (i_cmd.execute) begin
            r_pool  <= n_pool;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_used  <= n_used;
            r_fresh <= n_fresh;
        end
    end

    assign o_granted_block = r_granted;
    assign o_status        = r_status;
    assign o_free_count    = r_free;

endmodule

### sv/fixed_block_free_list_manager_unit.sv
// Top level of the fixed block free list manager.
`timescale 1ns / 1ps

// The block hands out and takes back equal blocks of a pool, named by index, kept
// on a FIFO free list. After reset, or a write of the pool size, blocks 0 to
// size-1 are free in ascending order.
// Requests: drive i_kind and i_block with start high; the transfer happens at a
// rising edge where start is high and busy is low. Kind 0 allocates the head
// block, kind 1 frees i_block to the tail, kind 2 releases every block.
// Results: o_done is high for exactly one cycle with o_granted_block, o_status
// and o_free_count valid; the receiver cannot stall, so it must take the result
// in that cycle. Exactly one result follows each request.
// Timing: busy rises for one cycle after a transfer and o_done follows in the
// next cycle; a new request is taken only once busy has fallen again. The exec
// state comes from the registered read of the head block's link in the link
// memory, which the allocation needs to advance the head.
// Configuration: i_cfg_we with i_cfg_wdata writes the pool size (clamped into
// 1..256) and rebuilds the list; write only while no request is in flight.
// Reset (i_rst_n low, synchronous) sets a pool of 256 blocks, all free; the link
// memory needs no clearing pass, since never-linked blocks chain implicitly.
module fixed_block_free_list_manager_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [fblm_pkg::IDX_W-1:0]  i_block,
    input  logic                        i_cfg_we,
    input  logic [fblm_pkg::CNT_W-1:0]  i_cfg_wdata,
    output logic                        o_done,
    output logic [fblm_pkg::IDX_W-1:0]  o_granted_block,
    output logic [1:0]                  o_status,
    output logic [fblm_pkg::CNT_W-1:0]  o_free_count
);

    fblm_pkg::t_dp_cmd dp_cmd;

    // The controller sequences each request through capture and execute.
    fblm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the list state, the link memory and the result registers.
    fblm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_kind          (i_kind),
        .i_block         (i_block),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_granted_block (o_granted_block),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule

### sv/fblm_checker.sv
// Port-level checker of the fixed block free list manager and its bind.
`timescale 1ns / 1ps

module fblm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [fblm_pkg::IDX_W-1:0]  o_granted_block,
    input logic [1:0]                  o_status,
    input logic [fblm_pkg::CNT_W-1:0]  o_free_count
);

    // A taken request makes the block busy in the next cycle.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request transfer");

    // Busy lasts exactly one cycle per request.
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A result comes in the cycle after the busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("result strobe missing after busy");

    // A failed request reports no granted block.
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != fblm_pkg::STAT_OK)) |-> (o_granted_block == '0))
        else $error("granted block reported on a failed request");

    // The free count never exceeds the pool capacity.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_free_count <= fblm_pkg::CNT_W'(fblm_pkg::MAX_BLOCKS)))
        else $error("free count beyond pool capacity");

endmodule

bind fixed_block_free_list_manager_unit fblm_checker u_fblm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_granted_block (o_granted_block),
    .o_status        (o_status),
    .o_free_count    (o_free_count)
);

### tb/tb_fixed_block_free_list_manager_unit.sv
// Testbench of the fixed block free list manager: a directed table, then random requests.
`timescale 1ns / 1ps

module tb_fixed_block_free_list_manager_unit;

    // The only kind value that the package leaves unnamed; the block must ignore it.
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // One result transfer as the block reports it.
    typedef struct packed {
        logic [fblm_pkg::IDX_W-1:0] granted;
        logic [1:0]                 status;
        logic [fblm_pkg::CNT_W-1:0] free_cnt;
    } t_reply;

    // A row of the directed table is either a request or a write of the pool size.
    typedef enum bit {ROW_REQUEST, ROW_POOL_WRITE} t_row_op;

    typedef struct packed {
        t_row_op                    op;
        logic [1:0]                 kind;
        logic [fblm_pkg::IDX_W-1:0] blk;
        logic [fblm_pkg::CNT_W-1:0] pool_value;
        bit                         typed;      // the reply below is checked as written
        logic [fblm_pkg::IDX_W-1:0] granted;
        logic [1:0]                 status;
        logic [fblm_pkg::CNT_W-1:0] free_cnt;
    } t_dir_row;

    // Directed part. Rows without a typed reply are checked against the predictor.
    // It covers a free with nothing in use, an exhausted pool, a freed index outside
    // the pool, a free into an empty list, the ignored kind, release-all, and pool
    // sizes of zero and above the maximum, which the block clamps.
    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_NONE_USED, 9'd256},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd255},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd1, fblm_pkg::STAT_OK,        9'd254},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd1,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd255},
        '{ROW_REQUEST,    KIND_IGNORED,           8'd255, 9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd255},
        '{ROW_REQUEST,    fblm_pkg::KIND_RELEASE, 8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd256},
        '{ROW_POOL_WRITE, fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b0, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_EXHAUSTED, 9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd1,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_BAD_INDEX, 9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd1},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_POOL_WRITE, fblm_pkg::KIND_ALLOC,   8'd0,   9'd511,
          1'b0, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd255, 9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_NONE_USED, 9'd256},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd255},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd256},
        '{ROW_POOL_WRITE, fblm_pkg::KIND_ALLOC,   8'd0,   9'd3,
          1'b0, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd2},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd1, fblm_pkg::STAT_OK,        9'd1},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd2},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b0, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b0, 8'd0, fblm_pkg::STAT_OK,        9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_ALLOC,   8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_EXHAUSTED, 9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_FREE,    8'd3,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_BAD_INDEX, 9'd0},
        '{ROW_REQUEST,    fblm_pkg::KIND_RELEASE, 8'd0,   9'd0,
          1'b1, 8'd0, fblm_pkg::STAT_OK,        9'd3}
    };

    // Random phases. Each phase writes its own pool size, small ones mostly so that
    // the pool runs dry often, plus the extremes and two values that must be clamped.
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 56;
    localparam logic [fblm_pkg::CNT_W-1:0] PHASE_POOL [PHASES] = '{
        9'd4, 9'd256, 9'd2, 9'd17, 9'd0, 9'd511, 9'd9, 9'd60
    };
    // Sender idle percentage, cycling through the phases. The third entry stands for
    // the receiver stalling, which this block's receiver cannot do, so it stays zero.
    localparam int PHASE_IDLE [4] = '{0, 70, 0, 31};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [1:0]                    i_kind;
    logic [fblm_pkg::IDX_W-1:0]    i_block;
    logic                          i_cfg_we;
    logic [fblm_pkg::CNT_W-1:0]    i_cfg_wdata;
    logic                          o_done;
    logic [fblm_pkg::IDX_W-1:0]    o_granted_block;
    logic [1:0]                    o_status;
    logic [fblm_pkg::CNT_W-1:0]    o_free_count;

    fixed_block_free_list_manager_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_block         (i_block),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_granted_block (o_granted_block),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

    // Predicted state of the free list. The link memory also records which entries
    // have been written since reset, so that the stimulus never makes the block read
    // an entry whose content is undefined.
    int unsigned                pool_size;
    int unsigned                used_blocks;
    int unsigned                fresh_upto; // blocks below this index left the initial chain
    logic [fblm_pkg::IDX_W-1:0] head_idx;
    logic [fblm_pkg::IDX_W-1:0] tail_idx;
    bit                         list_is_empty;
    logic [fblm_pkg::IDX_W-1:0] link_mem     [fblm_pkg::MAX_BLOCKS];
    bit                         link_written [fblm_pkg::MAX_BLOCKS];

    // Blocks that the stimulus believes to be handed out, used to form legal frees.
    bit                         block_in_use [fblm_pkg::MAX_BLOCKS];

    // Replies expected from the block, oldest first.
    t_reply                     pending_replies [$];
    int unsigned                error_count;

    // Every init puts blocks 0 to pool_size-1 on the list in ascending order; that
    // chain lives only implicitly until blocks are handed out and freed again.
    function automatic void rebuild_free_list();
        head_idx      = '0;
        tail_idx      = fblm_pkg::IDX_W'(pool_size - 1);
        list_is_empty = 1'b0;
        used_blocks   = 0;
        fresh_upto    = 0;
    endfunction

    function automatic void set_pool_size(input logic [fblm_pkg::CNT_W-1:0] value);
        int unsigned size;
        size = value;
        if (size == 0) begin
            size = 1;
        end else if (size > fblm_pkg::MAX_BLOCKS) begin
            size = fblm_pkg::MAX_BLOCKS;
        end
        pool_size = size;
        rebuild_free_list();
    endfunction

    // Next block on the list after idx: implicit while idx is still in the initial
    // chain, otherwise whatever a free wrote into the link memory.
    function automatic logic [fblm_pkg::IDX_W-1:0] successor_of(
            input logic [fblm_pkg::IDX_W-1:0] idx);
        if (int'(idx) >= fresh_upto && int'(idx) + 1 < pool_size) begin
            return fblm_pkg::IDX_W'(int'(idx) + 1);
        end
        return link_mem[idx];
    endfunction

    // True when an allocation now would fetch a link entry never written since reset.
    function automatic bit alloc_hits_unwritten();
        if (list_is_empty || used_blocks >= pool_size) begin
            return 1'b0;
        end
        if (head_idx == tail_idx || used_blocks + 1 >= pool_size) begin
            return 1'b0;
        end
        if (int'(head_idx) >= fresh_upto && int'(head_idx) + 1 < pool_size) begin
            return 1'b0;
        end
        return !link_written[head_idx];
    endfunction

    // Applies one request to the predicted free list and returns the reply it causes.
    function automatic t_reply apply_pool_request(input logic [1:0] kind,
                                                  input logic [fblm_pkg::IDX_W-1:0] blk);
        t_reply                     res;
        logic [fblm_pkg::IDX_W-1:0] taken;
        res.granted = '0;
        res.status  = fblm_pkg::STAT_OK;
        taken       = head_idx;
        case (kind)
            fblm_pkg::KIND_ALLOC: begin
                if (list_is_empty || used_blocks >= pool_size) begin
                    res.status = fblm_pkg::STAT_EXHAUSTED;
                end else begin
                    res.granted = taken;
                    if (taken == tail_idx || used_blocks + 1 >= pool_size) begin
                        list_is_empty = 1'b1;
                    end else begin
                        head_idx = successor_of(taken);
                    end
                    if (int'(taken) >= fresh_upto) begin
                        fresh_upto = int'(taken) + 1;
                    end
                    used_blocks++;
                end
            end
            fblm_pkg::KIND_FREE: begin
                if (used_blocks == 0) begin
                    res.status = fblm_pkg::STAT_NONE_USED;
                end else if (int'(blk) >= pool_size) begin
                    res.status = fblm_pkg::STAT_BAD_INDEX;
                end else begin
                    // A block freed into an empty list becomes its head as well.
                    if (list_is_empty) begin
                        head_idx      = blk;
                        list_is_empty = 1'b0;
                    end else begin
                        link_mem[tail_idx]     = blk;
                        link_written[tail_idx] = 1'b1;
                    end
                    tail_idx = blk;
                    used_blocks--;
                end
            end
            fblm_pkg::KIND_RELEASE: begin
                rebuild_free_list();
            end
            default: begin
                // The unused kind changes nothing and still gets an OK reply.
            end
        endcase
        res.free_cnt = fblm_pkg::CNT_W'(pool_size - used_blocks);
        return res;
    endfunction

    // Presents one request from the next falling edge on and holds it until the
    // block takes it; the transfer is the rising edge with start high and busy low.
    // The reply is predicted at that edge; a reply the caller typed in is expected instead.
    task automatic run_request(input logic [1:0] kind,
                               input logic [fblm_pkg::IDX_W-1:0] blk,
                               input bit typed, input t_reply typed_reply);
        t_reply predicted;
        @(negedge i_clk);
        start   <= 1'b1;
        i_kind  <= kind;
        i_block <= blk;
        do begin
            @(posedge i_clk);
        end while (busy);
        predicted = apply_pool_request(kind, blk);
        pending_replies.push_back(typed ? typed_reply : predicted);
        if (kind == fblm_pkg::KIND_ALLOC && predicted.status == fblm_pkg::STAT_OK) begin
            block_in_use[predicted.granted] = 1'b1;
        end else if (kind == fblm_pkg::KIND_FREE && predicted.status == fblm_pkg::STAT_OK) begin
            block_in_use[blk] = 1'b0;
        end else if (kind == fblm_pkg::KIND_RELEASE) begin
            block_in_use = '{default: 1'b0};
        end
    endtask

    // Random gap after a transfer. While start is low the request fields carry noise.
    task automatic sender_gap(input int idle_pct);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_kind  <= 2'($urandom_range(0, 3));
            i_block <= fblm_pkg::IDX_W'($urandom_range(0, fblm_pkg::MAX_BLOCKS - 1));
            while ($urandom_range(0, 99) < idle_pct) begin
                @(negedge i_clk);
            end
        end
    endtask

    // Stops sending and waits until every expected reply has arrived, then lets the
    // block settle so that it is surely idle.
    task automatic settle_replies();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Pool size writes happen only with the block idle; each one rebuilds the list.
    task automatic write_pool_size(input logic [fblm_pkg::CNT_W-1:0] value);
        settle_replies();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        set_pool_size(value);
        block_in_use = '{default: 1'b0};
    endtask

    // Random request. Most frees give back a block that is really in use, so that the
    // list gets deep; the rest are noise: random indexes, double frees, out-of-pool
    // indexes. An allocation that would read an undefined link turns into a release.
    task automatic pick_random_request(output logic [1:0] kind,
                                       output logic [fblm_pkg::IDX_W-1:0] blk);
        int unsigned alloc_pct;
        int unsigned roll;
        int unsigned in_use_cnt;
        int unsigned pick;
        alloc_pct = (pool_size >= 64) ? 70 : 50;
        blk       = fblm_pkg::IDX_W'($urandom_range(0, fblm_pkg::MAX_BLOCKS - 1));
        roll      = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < alloc_pct) begin
            kind = alloc_hits_unwritten() ? fblm_pkg::KIND_RELEASE : fblm_pkg::KIND_ALLOC;
        end else if (roll < 65) begin
            kind       = fblm_pkg::KIND_FREE;
            in_use_cnt = 0;
            foreach (block_in_use[b]) begin
                in_use_cnt += block_in_use[b];
            end
            if (in_use_cnt != 0) begin
                pick = $urandom_range(0, in_use_cnt - 1);
                foreach (block_in_use[b]) begin
                    if (block_in_use[b]) begin
                        if (pick == 0) begin
                            blk = fblm_pkg::IDX_W'(b);
                        end
                        pick--;
                    end
                end
            end
        end else if (roll < 83) begin
            kind = fblm_pkg::KIND_FREE;
        end else if (roll < 92) begin
            kind = fblm_pkg::KIND_RELEASE;
        end else begin
            kind = KIND_IGNORED;
        end
    endtask

    // Free-running clock, 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reply checker: every reply strobe is taken in its one cycle and compared with
    // the oldest expectation, field by field.
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: granted_block %0d status %0d free_count %0d",
                       o_granted_block, o_status, o_free_count);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_granted_block !== want.granted) begin
                    $error("granted_block mismatch: expected %0d, actual %0d",
                           want.granted, o_granted_block);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_status);
                    error_count++;
                end
                if (o_free_count !== want.free_cnt) begin
                    $error("free_count mismatch: expected %0d, actual %0d",
                           want.free_cnt, o_free_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog. The slowest legal run stays far below this bound, so reaching it
    // means the block stopped taking requests or stopped replying.
    initial begin
        #5_000_000;
        $display("FAIL fixed_block_free_list_manager_unit");
        $finish;
    end

    // Main sequence: reset, the directed table, then the random phases.
    initial begin : stimulus
        logic [1:0]                 kind;
        logic [fblm_pkg::IDX_W-1:0] blk;
        t_reply                     typed_reply;
        error_count  = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = fblm_pkg::KIND_ALLOC;
        i_block      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        block_in_use = '{default: 1'b0};
        set_pool_size(fblm_pkg::CNT_W'(fblm_pkg::MAX_BLOCKS));

        // Synchronous reset first; the block comes up with 256 free blocks.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, back to back.
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].op == ROW_POOL_WRITE) begin
                write_pool_size(DIRECTED[r].pool_value);
            end else begin
                typed_reply = '{DIRECTED[r].granted, DIRECTED[r].status,
                                DIRECTED[r].free_cnt};
                run_request(DIRECTED[r].kind, DIRECTED[r].blk, DIRECTED[r].typed,
                            typed_reply);
            end
        end

        // Random phases. Halfway through each one the sender waits until every
        // reply is in before it goes on.
        for (int p = 0; p < PHASES; p++) begin
            write_pool_size(PHASE_POOL[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    settle_replies();
                end
                pick_random_request(kind, blk);
                run_request(kind, blk, 1'b0, '0);
                sender_gap(PHASE_IDLE[p % 4]);
            end
        end

        // Drain what is still in flight, then report.
        settle_replies();
        if (error_count == 0) begin
            $display("PASS fixed_block_free_list_manager_unit");
        end else begin
            $display("FAIL fixed_block_free_list_manager_unit");
        end
        $finish;
    end

endmodule
